// ===== rtl/text_console_writer_top_defines.svh =====
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Concurrent checks on the clk domain, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCW_ASSERT_NOW(label, ante, cons, msg)
`define TCW_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console writer package
// Field widths, codes and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int COL_W       = 7;
  localparam int ROW_W       = 5;
  localparam int LIN_W       = 11;
  localparam int LIN_FULL_W  = COL_W + ROW_W;
  localparam int CHAR_W      = 8;
  localparam int COLOR_W     = 8;
  localparam int CELL_W      = CHAR_W + COLOR_W;
  localparam int TW_W        = 5;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_ADDR_W-1:0] CFG_BLANK_COLOR = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TAB_WIDTH   = 1'b1;

  localparam logic [CHAR_W-1:0]  CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0]  CHAR_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0]  CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0]  CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0]  CHAR_BLANK = 8'h00;
  localparam logic [COLOR_W-1:0] RESET_COLOR     = 8'h07;
  localparam logic [TW_W-1:0]    RESET_TAB_WIDTH = 5'd4;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RD_ACCEPT = 2'd0,
    RD_CURSOR = 2'd1,
    RD_SCROLL = 2'd2
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_CHAR = 2'd1,
    WR_CELL = 2'd2,
    WR_FILL = 2'd3
  } wr_sel_t;

  typedef enum logic [2:0] {
    CUR_HOLD = 3'd0,
    CUR_ADV  = 3'd1,
    CUR_NL   = 3'd2,
    CUR_CR   = 3'd3,
    CUR_HOME = 3'd4
  } cur_op_t;

  typedef enum logic [1:0] {
    SC_HOLD = 2'd0,
    SC_ZERO = 2'd1,
    SC_INC  = 2'd2
  } sc_op_t;

  typedef struct packed {
    logic    in_load;
    logic    rd_en;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    use_space;
    logic    fill_boot;
    cur_op_t cur_op;
    sc_op_t  sc_op;
    logic    div_start;
    logic    div_step;
    logic    n_load;
    logic    n_dec;
    logic    res_load;
    logic    out_load;
  } tcw_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic is_nl;
    logic is_cr;
    logic is_tab;
    logic adv_scroll;
    logic nl_scroll;
    logic sc_copy_last;
    logic sc_last;
    logic div_done;
    logic n_last;
    logic n_zero;
    logic out_free;
  } tcw_stat_t;

endpackage

// ===== rtl/text_console_writer_top.sv =====
// ----------------------------------------------------------------------------
// Text console writer
// Character cell console of ROWS x COLUMNS cells with a cursor, run as a
// controller and a datapath around one screen store with one read and one write port.
// ----------------------------------------------------------------------------
// After reset the store is swept to character 0, colour 7, one cell a cycle,
// with in_tready low; configuration writes are taken throughout. Put
// character, carriage return, newline, write cell and read cell are each
// finished before the next request is taken; the result register lets the
// next request in while a result waits. A tab first works out the column
// remainder, then reads and writes each space in turn. A scroll walks the
// store once, one cell a cycle through its read port and its write port.
// Clear screen sweeps every cell of the store.
`timescale 1ns / 1ps
`include "text_console_writer_top_defines.svh"
module text_console_writer_top import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // command, char_code, cell_col, cell_row, cell_color
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // cursor_col, cursor_row, cursor_linear, read_char, read_color, status
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  tcw_cmd_t  dp_cmd;
  tcw_stat_t dp_stat;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  tcw_dpath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (dp_cmd),
    .stat       (dp_stat)
  );

  `TCW_ASSERT_NEXT(a_one_request, in_tvalid && in_tready, !in_tready, "request taken while busy")
  `TCW_ASSERT_NOW(a_no_overwrite, dp_cmd.out_load, !out_tvalid || out_tready, "result overwritten")
  `TCW_ASSERT_NOW(a_bad_read_zero, out_tvalid && out_tdata[39], out_tdata[38:23] == '0, "bad read data")
  `TCW_ASSERT_NOW(a_cursor_range, out_tvalid, (int'(out_tdata[6:0]) < COLUMNS) && (int'(out_tdata[11:7]) < ROWS), "cursor out of range")

endmodule

// ===== rtl/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences each request: cell access, tab expansion, scroll and clear sweeps,
// and the power-up clearing pass of the screen store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tcw_ctrl import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  tcw_stat_t stat,
  output tcw_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_BOOT      = 11'b00000000001,
    S_IDLE      = 11'b00000000010,
    S_EXEC      = 11'b00000000100,
    S_DIV       = 11'b00000001000,
    S_TAB_RD    = 11'b00000010000,
    S_TAB_WR    = 11'b00000100000,
    S_SCR_COPY  = 11'b00001000000,
    S_SCR_DRAIN = 11'b00010000000,
    S_SCR_BLANK = 11'b00100000000,
    S_CLEAR     = 11'b01000000000,
    S_HOLD      = 11'b10000000000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   go_fin;
  logic   go_scroll;

  always_comb begin
    state_nxt     = state_r;
    cmd.in_load   = 1'b0;
    cmd.rd_en     = 1'b0;
    cmd.rd_sel    = RD_CURSOR;
    cmd.wr_sel    = WR_NONE;
    cmd.use_space = 1'b0;
    cmd.fill_boot = 1'b0;
    cmd.cur_op    = CUR_HOLD;
    cmd.sc_op     = SC_HOLD;
    cmd.div_start = 1'b0;
    cmd.div_step  = 1'b0;
    cmd.n_load    = 1'b0;
    cmd.n_dec     = 1'b0;
    cmd.res_load  = 1'b0;
    cmd.out_load  = 1'b0;
    go_fin        = 1'b0;
    go_scroll     = 1'b0;
    case (state_r)
      S_BOOT: begin
        cmd.wr_sel    = WR_FILL;
        cmd.fill_boot = 1'b1;
        cmd.sc_op     = SC_INC;
        if (stat.sc_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.in_load = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_ACCEPT;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.res_load = 1'b1;
        case (stat.cmd)
          CMD_PUT: begin
            if (stat.is_nl) begin
              cmd.cur_op = CUR_NL;
              go_scroll  = stat.nl_scroll;
              go_fin     = !stat.nl_scroll;
            end else if (stat.is_cr) begin
              cmd.cur_op = CUR_CR;
              go_fin     = 1'b1;
            end else if (stat.is_tab) begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end else begin
              cmd.wr_sel = WR_CHAR;
              cmd.cur_op = CUR_ADV;
              go_scroll  = stat.adv_scroll;
              go_fin     = !stat.adv_scroll;
            end
          end
          CMD_WRITE: begin
            cmd.wr_sel = WR_CELL;
            go_fin     = 1'b1;
          end
          CMD_READ: begin
            go_fin = 1'b1;
          end
          CMD_CLEAR: begin
            cmd.sc_op  = SC_ZERO;
            cmd.cur_op = CUR_HOME;
            state_nxt  = S_CLEAR;
          end
          default: begin
            go_fin = 1'b1;
          end
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          cmd.n_load = 1'b1;
          state_nxt  = S_TAB_RD;
        end
      end
      S_TAB_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_CURSOR;
        state_nxt  = S_TAB_WR;
      end
      S_TAB_WR: begin
        cmd.wr_sel    = WR_CHAR;
        cmd.use_space = 1'b1;
        cmd.cur_op    = CUR_ADV;
        cmd.n_dec     = 1'b1;
        if (stat.adv_scroll) begin
          go_scroll = 1'b1;
        end else if (stat.n_last) begin
          go_fin = 1'b1;
        end else begin
          state_nxt = S_TAB_RD;
        end
      end
      S_SCR_COPY: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_SCROLL;
        cmd.sc_op  = SC_INC;
        if (stat.sc_copy_last) begin
          state_nxt = S_SCR_DRAIN;
        end
      end
      S_SCR_DRAIN: begin
        state_nxt = S_SCR_BLANK;
      end
      S_SCR_BLANK: begin
        cmd.wr_sel = WR_FILL;
        cmd.sc_op  = SC_INC;
        if (stat.sc_last) begin
          if (stat.n_zero) begin
            go_fin = 1'b1;
          end else begin
            state_nxt = S_TAB_RD;
          end
        end
      end
      S_CLEAR: begin
        cmd.wr_sel = WR_FILL;
        cmd.sc_op  = SC_INC;
        go_fin     = stat.sc_last;
      end
      S_HOLD: begin
        go_fin = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (go_scroll) begin
      cmd.sc_op = SC_ZERO;
      state_nxt = S_SCR_COPY;
    end
    if (go_fin) begin
      if (stat.out_free) begin
        cmd.out_load = 1'b1;
        state_nxt    = S_IDLE;
      end else begin
        state_nxt = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BOOT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

// ===== rtl/tcw_dpath.sv =====
// ----------------------------------------------------------------------------
// Text console writer datapath
// Screen store, cursor, sweep counter, tab divider, configuration registers
// and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tcw_dpath import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  tcw_cmd_t               cmd,
  output tcw_stat_t              stat
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam logic [COL_W-1:0]  LAST_COL = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] SC_COPY_END = ADDR_W'(CELLS - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] SC_END = ADDR_W'(CELLS - 1);

  // request fields
  cmd_t                cmd_r;
  logic [CHAR_W-1:0]   char_r;
  logic [COL_W-1:0]    ccol_r;
  logic [ROW_W-1:0]    crow_r;
  logic [COLOR_W-1:0]  ccolor_r;
  cmd_t                in_cmd;
  logic [COL_W-1:0]    in_col;
  logic [ROW_W-1:0]    in_row;

  // cursor and sweep
  logic [COL_W-1:0]    col_r;
  logic [COL_W-1:0]    col_nxt;
  logic [ROW_W-1:0]    line_r;
  logic [ROW_W-1:0]    line_nxt;
  logic [ADDR_W-1:0]   sc_r;
  logic [ADDR_W-1:0]   sc_nxt;
  logic                cp_pend_r;
  logic [ADDR_W-1:0]   cp_dst_r;

  // tab divider
  logic [TW_W-1:0]     rem_r;
  logic [TW_W-1:0]     rem_step;
  logic [TW_W:0]       rem_sh;
  logic [2:0]          div_idx_r;
  logic [TW_W-1:0]     n_r;
  logic [TW_W-1:0]     tw_eff;

  // configuration
  logic [COLOR_W-1:0]  blank_color_r;
  logic [TW_W-1:0]     tab_width_r;

  // addresses
  logic [LIN_FULL_W-1:0] cur_full;
  logic [LIN_FULL_W-1:0] in_full;
  logic [LIN_FULL_W-1:0] cell_full;
  logic [LIN_FULL_W-1:0] lin_full;
  logic [ADDR_W-1:0]     cur_addr;
  logic                  cell_ok;

  // store ports
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [CELL_W-1:0]   ram_rdata;

  // result
  logic [CHAR_W-1:0]   res_char_r;
  logic [CHAR_W-1:0]   res_char_nxt;
  logic [COLOR_W-1:0]  res_color_r;
  logic [COLOR_W-1:0]  res_color_nxt;
  logic                res_status_r;
  logic                res_status_nxt;
  logic                out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  assign in_cmd = cmd_t'(in_tdata[1:0]);
  assign in_col = in_tdata[16:10];
  assign in_row = in_tdata[21:17];

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      cmd_r    <= in_cmd;
      char_r   <= in_tdata[9:2];
      ccol_r   <= in_col;
      crow_r   <= in_row;
      ccolor_r <= in_tdata[29:22];
    end
  end

  assign cur_full  = {{COL_W{1'b0}}, line_r} * LIN_FULL_W'(COLUMNS) + {{ROW_W{1'b0}}, col_r};
  assign in_full   = {{COL_W{1'b0}}, in_row} * LIN_FULL_W'(COLUMNS) + {{ROW_W{1'b0}}, in_col};
  assign cell_full = {{COL_W{1'b0}}, crow_r} * LIN_FULL_W'(COLUMNS) + {{ROW_W{1'b0}}, ccol_r};
  assign cur_addr  = cur_full[ADDR_W-1:0];
  assign cell_ok   = (int'(ccol_r) < COLUMNS) && (int'(crow_r) < ROWS);

  always_comb begin
    case (cmd.rd_sel)
      RD_ACCEPT: ram_raddr = (in_cmd == CMD_READ) ? in_full[ADDR_W-1:0] : cur_addr;
      RD_CURSOR: ram_raddr = cur_addr;
      RD_SCROLL: ram_raddr = sc_r + ADDR_W'(COLUMNS);
      default:   ram_raddr = cur_addr;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = ram_rdata;
    if (cp_pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = cp_dst_r;
      ram_wdata = ram_rdata;
    end else begin
      case (cmd.wr_sel)
        WR_NONE: begin
          ram_we = 1'b0;
        end
        WR_CHAR: begin
          ram_we    = 1'b1;
          ram_waddr = cur_addr;
          ram_wdata = {ram_rdata[CELL_W-1:CHAR_W], cmd.use_space ? CHAR_SPACE : char_r};
        end
        WR_CELL: begin
          ram_we    = cell_ok;
          ram_waddr = cell_full[ADDR_W-1:0];
          ram_wdata = {ccolor_r, char_r};
        end
        WR_FILL: begin
          ram_we    = 1'b1;
          ram_waddr = sc_r;
          ram_wdata = {cmd.fill_boot ? RESET_COLOR : blank_color_r, CHAR_BLANK};
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    col_nxt  = col_r;
    line_nxt = line_r;
    case (cmd.cur_op)
      CUR_HOLD: begin
        col_nxt = col_r;
      end
      CUR_ADV: begin
        if (col_r == LAST_COL) begin
          col_nxt = '0;
          if (line_r != LAST_ROW) begin
            line_nxt = line_r + 1'b1;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      CUR_NL: begin
        col_nxt = '0;
        if (line_r != LAST_ROW) begin
          line_nxt = line_r + 1'b1;
        end
      end
      CUR_CR: begin
        col_nxt = '0;
      end
      CUR_HOME: begin
        col_nxt  = '0;
        line_nxt = '0;
      end
      default: begin
        col_nxt = col_r;
      end
    endcase
  end

  always_comb begin
    case (cmd.sc_op)
      SC_HOLD: sc_nxt = sc_r;
      SC_ZERO: sc_nxt = '0;
      SC_INC:  sc_nxt = sc_r + 1'b1;
      default: sc_nxt = sc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      line_r    <= '0;
      sc_r      <= '0;
      cp_pend_r <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      line_r    <= line_nxt;
      sc_r      <= sc_nxt;
      cp_pend_r <= cmd.rd_en && (cmd.rd_sel == RD_SCROLL);
    end
  end

  always_ff @(posedge clk) begin
    cp_dst_r <= sc_r;
  end

  // restoring remainder of the cursor column, one column bit a cycle
  assign tw_eff   = (tab_width_r == '0) ? TW_W'(1) : tab_width_r;
  assign rem_sh   = {rem_r, col_r[div_idx_r]};
  assign rem_step = (rem_sh >= {1'b0, tw_eff}) ? TW_W'(rem_sh - {1'b0, tw_eff})
                                                : rem_sh[TW_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r     <= '0;
      div_idx_r <= '0;
      n_r       <= '0;
    end else begin
      if (cmd.div_start) begin
        rem_r     <= '0;
        div_idx_r <= 3'(COL_W - 1);
      end else if (cmd.div_step) begin
        rem_r     <= rem_step;
        div_idx_r <= div_idx_r - 1'b1;
      end
      if (cmd.n_load) begin
        n_r <= tw_eff - rem_step;
      end else if (cmd.n_dec) begin
        n_r <= n_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_color_r <= RESET_COLOR;
      tab_width_r   <= RESET_TAB_WIDTH;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_BLANK_COLOR) begin
        blank_color_r <= cfg_wdata[COLOR_W-1:0];
      end
      if (cfg_addr == CFG_TAB_WIDTH) begin
        tab_width_r <= cfg_wdata[TW_W-1:0];
      end
    end
  end

  always_comb begin
    res_char_nxt   = res_char_r;
    res_color_nxt  = res_color_r;
    res_status_nxt = res_status_r;
    if (cmd.res_load) begin
      res_char_nxt   = '0;
      res_color_nxt  = '0;
      res_status_nxt = ((cmd_r == CMD_WRITE) || (cmd_r == CMD_READ)) && !cell_ok;
      if ((cmd_r == CMD_READ) && cell_ok) begin
        res_char_nxt  = ram_rdata[CHAR_W-1:0];
        res_color_nxt = ram_rdata[CELL_W-1:CHAR_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    res_char_r   <= res_char_nxt;
    res_color_r  <= res_color_nxt;
    res_status_r <= res_status_nxt;
  end

  assign lin_full = {{COL_W{1'b0}}, line_nxt} * LIN_FULL_W'(COLUMNS) + {{ROW_W{1'b0}}, col_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {res_status_nxt, res_color_nxt, res_char_nxt,
                     lin_full[LIN_W-1:0], line_nxt, col_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign stat.cmd          = cmd_r;
  assign stat.is_nl        = (char_r == CHAR_NL);
  assign stat.is_cr        = (char_r == CHAR_CR);
  assign stat.is_tab       = (char_r == CHAR_TAB);
  assign stat.adv_scroll   = (col_r == LAST_COL) && (line_r == LAST_ROW);
  assign stat.nl_scroll    = (line_r == LAST_ROW);
  assign stat.sc_copy_last = (sc_r == SC_COPY_END);
  assign stat.sc_last      = (sc_r == SC_END);
  assign stat.div_done     = (div_idx_r == '0);
  assign stat.n_last       = (n_r == TW_W'(1));
  assign stat.n_zero       = (n_r == '0);
  assign stat.out_free     = !out_valid_r || out_tready;

endmodule

// ===== dv/text_console_writer_checker.sv =====
// ----------------------------------------------------------------------------
// Text console writer checker
// Watches the request, result and register ports, keeps its own screen,
// cursor and register copies, predicts one result per accepted request and
// compares every returned result field by field, oldest first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module text_console_writer_checker import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int unsigned            failures,
  output int unsigned            pending
);

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [1:0]         pad;
    logic [COLOR_W-1:0] cell_color;
    logic [ROW_W-1:0]   cell_row;
    logic [COL_W-1:0]   cell_col;
    logic [CHAR_W-1:0]  char_code;
    cmd_t               command;
  } console_request_t;

  typedef struct packed {
    logic               status;
    logic [COLOR_W-1:0] read_color;
    logic [CHAR_W-1:0]  read_char;
    logic [LIN_W-1:0]   cursor_linear;
    logic [ROW_W-1:0]   cursor_row;
    logic [COL_W-1:0]   cursor_col;
  } console_result_t;

  logic [CELL_W-1:0]  screen [CELLS];
  int unsigned        cur_col;
  int unsigned        cur_row;
  logic [COLOR_W-1:0] blank_attr;
  logic [TW_W-1:0]    tab_span;
  console_result_t    awaited_results [$];

  task automatic report_mismatch(input string what, input logic [OUT_TDATA_W-1:0] want,
                                 input logic [OUT_TDATA_W-1:0] got);
    if (failures < 200)
      $display("%0t checker: %s expected %0h got %0h", $realtime, what, want, got);
    failures++;
  endtask

  function automatic void scroll_screen();
    int i;
    for (i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
    for (i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {blank_attr, CHAR_BLANK};
  endfunction

  function automatic void settle_cursor();
    if (cur_col >= COLUMNS) begin
      cur_col -= COLUMNS;
      cur_row++;
    end
    if (cur_row >= ROWS) begin
      scroll_screen();
      cur_row = ROWS - 1;
    end
  endfunction

  // keep the cell's colour, replace the character, then advance
  function automatic void place_glyph(input logic [CHAR_W-1:0] ch);
    int unsigned idx;
    idx = cur_row * COLUMNS + cur_col;
    screen[idx][CHAR_W-1:0] = ch;
    cur_col++;
    settle_cursor();
  endfunction

  function automatic void type_char(input logic [CHAR_W-1:0] ch);
    int unsigned span;
    int unsigned spaces;
    if (ch == CHAR_NL) begin
      cur_col = 0;
      cur_row++;
      settle_cursor();
    end else if (ch == CHAR_CR) begin
      cur_col = 0;
      settle_cursor();
    end else if (ch == CHAR_TAB) begin
      // the space count is fixed from the column before the first space
      span   = (tab_span == 0) ? 1 : tab_span;
      spaces = span - (cur_col % span);
      repeat (spaces) place_glyph(CHAR_SPACE);
      settle_cursor();
    end else begin
      place_glyph(ch);
    end
  endfunction

  function automatic console_result_t run_console_command(input console_request_t req);
    console_result_t res;
    logic            on_screen;
    int unsigned     idx;
    int              i;
    res       = '0;
    on_screen = (req.cell_col < COLUMNS) && (req.cell_row < ROWS);
    idx       = req.cell_row * COLUMNS + req.cell_col;
    case (req.command)
      CMD_PUT: begin
        type_char(req.char_code);
      end
      CMD_WRITE: begin
        if (on_screen) screen[idx] = {req.cell_color, req.char_code};
        else res.status = 1'b1;
      end
      CMD_READ: begin
        if (on_screen) {res.read_color, res.read_char} = screen[idx];
        else res.status = 1'b1;
      end
      CMD_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen[i] = {blank_attr, CHAR_BLANK};
        cur_col = 0;
        cur_row = 0;
      end
      default: begin
      end
    endcase
    res.cursor_col    = COL_W'(cur_col);
    res.cursor_row    = ROW_W'(cur_row);
    res.cursor_linear = LIN_W'(cur_row * COLUMNS + cur_col);
    return res;
  endfunction

  task automatic check_result(input console_result_t got);
    console_result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("result with no request outstanding", '0, got);
    end else begin
      want = awaited_results.pop_front();
      if (got.cursor_col !== want.cursor_col)
        report_mismatch("cursor_col", want.cursor_col, got.cursor_col);
      if (got.cursor_row !== want.cursor_row)
        report_mismatch("cursor_row", want.cursor_row, got.cursor_row);
      if (got.cursor_linear !== want.cursor_linear)
        report_mismatch("cursor_linear", want.cursor_linear, got.cursor_linear);
      if (got.read_char !== want.read_char)
        report_mismatch("read_char", want.read_char, got.read_char);
      if (got.read_color !== want.read_color)
        report_mismatch("read_color", want.read_color, got.read_color);
      if (got.status !== want.status)
        report_mismatch("status", want.status, got.status);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) screen[i] = {RESET_COLOR, CHAR_BLANK};
      cur_col    = 0;
      cur_row    = 0;
      blank_attr = RESET_COLOR;
      tab_span   = RESET_TAB_WIDTH;
      failures   = 0;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_BLANK_COLOR: blank_attr = cfg_wdata[COLOR_W-1:0];
          CFG_TAB_WIDTH:   tab_span   = cfg_wdata[TW_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_tvalid && out_tready) check_result(console_result_t'(out_tdata));
      if (in_tvalid && in_tready)
        awaited_results.push_back(run_console_command(console_request_t'(in_tdata)));
    end
    pending = awaited_results.size();
  end

endmodule

// ===== dv/text_console_writer_top_tb.sv =====
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives directed and random console requests with random gaps on both
// streams and one long result back-pressure stretch, reprogramming blank
// colour and tab width between phases; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module text_console_writer_top_tb;
  import tcw_pkg::*;

  localparam int          COLUMNS     = 80;
  localparam int          ROWS        = 25;
  localparam int unsigned CYCLE_LIMIT = 6_000_000;
  localparam int unsigned TAIL_CYCLES = 2_100;
  localparam int unsigned PHASE_SIZE  = 156;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  int unsigned            failures;
  int unsigned            pending;
  int unsigned            sent;
  logic                   steady_in;

  text_console_writer_top #(.COLUMNS(COLUMNS), .ROWS(ROWS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  text_console_writer_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) console_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .failures   (failures),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[text_console_writer_top] ERROR");
    $finish;
  end

  // result side: random stalls, calm stretches, and one long hold-off
  initial begin : result_sink
    int unsigned hold;
    int unsigned taken;
    logic        calm;
    out_tready <= 1'b0;
    taken = 0;
    calm  = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      hold = calm ? 0 : $urandom_range(0, 18);
      if (taken == 250) hold = 600;
      if (hold != 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  task automatic send_request(input cmd_t cmd, input logic [CHAR_W-1:0] ch,
                              input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                              input logic [COLOR_W-1:0] color);
    int unsigned gap;
    if (sent % 48 == 0) steady_in = ($urandom_range(0, 3) == 0);
    gap = steady_in ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, color, row, col, ch, cmd};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic send_put(input logic [CHAR_W-1:0] ch);
    send_request(CMD_PUT, ch, COL_W'($urandom), ROW_W'($urandom), COLOR_W'($urandom));
  endtask

  function automatic logic [CHAR_W-1:0] pick_glyph();
    if ($urandom_range(0, 3) != 0) return CHAR_W'($urandom_range(8'h20, 8'h7E));
    return CHAR_W'($urandom);
  endfunction

  function automatic logic [COL_W-1:0] pick_col();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return COL_W'(COLUMNS - 1);
      default: return COL_W'($urandom_range(0, COLUMNS - 1));
    endcase
  endfunction

  function automatic logic [ROW_W-1:0] pick_row();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ROW_W'(ROWS - 1);
      default: return ROW_W'($urandom_range(0, ROWS - 1));
    endcase
  endfunction

  task automatic send_burst();
    int unsigned        kind;
    int unsigned        len;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      len = $urandom_range(0, 40);
      repeat (len) send_put(pick_glyph());
      if ($urandom_range(0, 3) == 0) send_put(CHAR_CR);
      if ($urandom_range(0, 3) != 0) send_put(CHAR_NL);
    end else if (kind < 52) begin
      len = $urandom_range(1, 6);
      repeat (len) begin
        send_put(CHAR_TAB);
        if ($urandom_range(0, 1) == 0) send_put(pick_glyph());
      end
    end else if (kind < 60) begin
      len = $urandom_range(1, 30);
      repeat (len) send_put(CHAR_NL);
    end else if (kind < 85) begin
      col = pick_col();
      row = pick_row();
      send_request(CMD_WRITE, CHAR_W'($urandom), col, row, COLOR_W'($urandom));
      send_request(CMD_READ, CHAR_W'($urandom), col, row, COLOR_W'($urandom));
      if ($urandom_range(0, 1) == 0)
        send_request(CMD_READ, CHAR_W'($urandom), pick_col(), pick_row(), COLOR_W'($urandom));
    end else if (kind < 97) begin
      len = $urandom_range(1, 4);
      repeat (len)
        send_request(cmd_t'($urandom_range(0, 3)), CHAR_W'($urandom), COL_W'($urandom),
                     ROW_W'($urandom), COLOR_W'($urandom));
    end else begin
      send_request(CMD_CLEAR, CHAR_W'($urandom), COL_W'($urandom), ROW_W'($urandom),
                   COLOR_W'($urandom));
    end
  endtask

  // drop the request, then hold until every result is back
  task automatic drain_phase();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic program_console(input logic [COLOR_W-1:0] blank, input logic [TW_W-1:0] span);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_BLANK_COLOR;
    cfg_wdata <= blank;
    @(posedge clk);
    cfg_addr  <= CFG_TAB_WIDTH;
    cfg_wdata <= CFG_DATA_W'(span);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    logic [COLOR_W-1:0] blank_plan [5];
    logic [TW_W-1:0]    span_plan [5];
    int unsigned        target;
    blank_plan = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h00};
    span_plan  = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd4};
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    sent      = 0;
    steady_in = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset contents, field extremes, out-of-range cells
    send_request(CMD_READ, 8'h00, 7'd0, 5'd0, 8'h00);
    send_request(CMD_READ, 8'hFF, 7'(COLUMNS - 1), 5'(ROWS - 1), 8'hFF);
    send_request(CMD_WRITE, 8'hFF, 7'd0, 5'd0, 8'hFF);
    send_request(CMD_WRITE, 8'h00, 7'(COLUMNS - 1), 5'(ROWS - 1), 8'h00);
    send_request(CMD_READ, 8'h00, 7'd0, 5'd0, 8'h00);
    send_request(CMD_READ, 8'h00, 7'(COLUMNS - 1), 5'(ROWS - 1), 8'h00);
    send_request(CMD_WRITE, 8'h41, 7'(COLUMNS), 5'd0, 8'h12);
    send_request(CMD_WRITE, 8'hFF, 7'h7F, 5'h1F, 8'hFF);
    send_request(CMD_READ, 8'h00, 7'd0, 5'(ROWS), 8'h00);
    send_request(CMD_READ, 8'hFF, 7'h7F, 5'h1F, 8'hFF);
    // put character: ordinary bytes, tabs, carriage return, newline
    send_request(CMD_PUT, 8'h41, 7'h7F, 5'h1F, 8'hFF);
    send_put(8'h00);
    send_put(8'hFF);
    send_put(CHAR_TAB);
    send_put(CHAR_TAB);
    send_put(CHAR_CR);
    send_put(CHAR_NL);
    send_request(CMD_READ, 8'h00, 7'd0, 5'd0, 8'h00);
    send_request(CMD_CLEAR, 8'hFF, 7'h7F, 5'h1F, 8'hFF);
    send_request(CMD_READ, 8'h00, 7'd0, 5'd0, 8'h00);
    drain_phase();

    for (int p = 0; p < 5; p++) begin
      if (p == 4) program_console(COLOR_W'($urandom), TW_W'($urandom_range(1, 16)));
      else program_console(blank_plan[p], span_plan[p]);
      target = sent + PHASE_SIZE;
      while (sent < target) send_burst();
      drain_phase();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) $display("[text_console_writer_top] OK");
    else $display("[text_console_writer_top] ERROR");
    $finish;
  end

endmodule
